// ===== src/vphd_pkg.sv =====
`timescale 1ns / 1ps

package vphd_pkg;

  // shift-add multiplier: one multiplier bit per cycle
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // restoring divider: one quotient bit per cycle
  localparam int DIV_N_W   = 56;
  localparam int DIV_D_W   = 24;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

  typedef struct packed {
    logic               go;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic               go;
    logic [DIV_N_W-1:0] n;
    logic [DIV_D_W-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] q;
  } div_rsp_t;

endpackage

// ===== src/vphd_ifs.sv =====
`timescale 1ns / 1ps

// position word in
interface vphd_pos_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [19:0] delta_time_us;
  modport source (output valid, output pos_x, output pos_y, output delta_time_us,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input delta_time_us,
                output ready);
endinterface

// velocity word out
interface vphd_vel_if;
  logic        valid;
  logic        ready;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  modport source (output valid, output vel_x, output vel_y, input ready);
  modport sink (input valid, input vel_x, input vel_y, output ready);
endinterface

// register write channel
interface vphd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vphd_pkg::CFG_IDX_W-1:0]   index;
  logic [vphd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/vphd_mul.sv =====
`timescale 1ns / 1ps

// Unsigned shift-add multiplier, one bit of b per cycle.
module vphd_mul (
  input  logic               clk,
  input  logic               rst,
  input  vphd_pkg::mul_req_t req,
  output vphd_pkg::mul_rsp_t rsp
);

  logic [vphd_pkg::MUL_A_W-1:0]   a_r;
  logic [vphd_pkg::MUL_B_W-1:0]   b_r;
  logic [vphd_pkg::MUL_P_W-1:0]   p;
  logic [vphd_pkg::MUL_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [vphd_pkg::MUL_A_W:0]     psum;

  // add multiplicand into the upper half when the current bit is set
  always_comb begin
    psum = {1'b0, p[vphd_pkg::MUL_P_W-1:vphd_pkg::MUL_B_W]} +
           (b_r[0] ? {1'b0, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        a_r  <= req.a;
        b_r  <= req.b;
        p    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        p   <= {psum, p[vphd_pkg::MUL_B_W-1:1]};
        b_r <= b_r >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == vphd_pkg::MUL_CNT_W'(vphd_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = p;

endmodule

// ===== src/vphd_div.sv =====
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
module vphd_div (
  input  logic               clk,
  input  logic               rst,
  input  vphd_pkg::div_req_t req,
  output vphd_pkg::div_rsp_t rsp
);

  logic [vphd_pkg::DIV_N_W-1:0]   n_r;
  logic [vphd_pkg::DIV_D_W-1:0]   d_r;
  logic [vphd_pkg::DIV_D_W-1:0]   rem;
  logic [vphd_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [vphd_pkg::DIV_D_W:0]     rshift;
  logic [vphd_pkg::DIV_D_W:0]     rdiff;
  logic                           qbit;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rshift = {rem, n_r[vphd_pkg::DIV_N_W-1]};
    rdiff  = rshift - {1'b0, d_r};
    qbit   = (rshift >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        n_r  <= req.n;
        d_r  <= req.d;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= qbit ? rdiff[vphd_pkg::DIV_D_W-1:0] : rshift[vphd_pkg::DIV_D_W-1:0];
        n_r <= {n_r[vphd_pkg::DIV_N_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == vphd_pkg::DIV_CNT_W'(vphd_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = n_r;

endmodule

// ===== src/velocity_peak_hold_decay.sv =====
`timescale 1ns / 1ps
// A multiply is a 32-step shift-add, a divide a 56-step restoring division. Decay off: a first
// or zero-time word goes straight to the result, else each of the two axes runs a multiply,
// a divide and a gain multiply. Decay on: adds a ratio divide, 12 Taylor multiply/divide pairs,
// up to 32 e^-1 multiplies and 4 to 6 more multiplies. One word in flight; the next word is taken
// the cycle after the result loads, and waits while a result word is stalled.
// Reset (rst, synchronous): registers to their reset values, held and last state cleared.
module velocity_peak_hold_decay (
  input logic        clk,
  input logic        rst,
  vphd_pos_if.sink   pos,
  vphd_vel_if.source vel,
  vphd_cfg_if.sink   cfg
);

  localparam logic [31:0] VEL_SCALE   = 32'd1000000;
  localparam logic [31:0] EINV_Q30    = 32'd395007542;
  localparam logic [47:0] VEL_CLAMP   = 48'h8000_0000_0000;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [3:0]  TAYLOR_LAST = 4'd12;
  localparam logic [5:0]  EXP_MAX     = 6'd32;
  localparam logic [15:0] GAIN_RESET  = 16'd256;
  localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN     = 32'h8000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INST, ST_V_MUL, ST_V_DIV, ST_V_GAIN, ST_KSTART, ST_R_DIV,
    ST_T_MUL, ST_T_DIV, ST_E_START, ST_E_MUL, ST_KFIN, ST_D_MUL, ST_SQ_MUL,
    ST_PEAK, ST_B_MUL, ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [15:0] gain;
  logic [23:0] tau;
  logic        peak;

  // held state
  logic [31:0] last_x, last_y, held_x, held_y;
  logic        have_last;

  // working registers
  logic [31:0] px, py, ix, iy, tsum;
  logic [19:0] dt;
  logic        axis, neg;
  logic [29:0] xq;
  logic [30:0] qe;
  logic [3:0]  tk;
  logic [5:0]  ecnt;
  logic [15:0] kf;
  logic [65:0] sqdiff;
  logic [1:0]  sqi;
  logic        out_valid;
  logic [31:0] out_x, out_y;

  vphd_pkg::mul_req_t mreq;
  vphd_pkg::mul_rsp_t mrsp;
  vphd_pkg::div_req_t dreq;
  vphd_pkg::div_rsp_t drsp;

  vphd_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  vphd_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // datapath helpers
  logic [31:0] sel_p, sel_l, d_mag, g_neg, inst_val;
  logic [32:0] d_diff;
  logic [47:0] v_clamp;
  logic [55:0] g_mag;
  logic [35:0] ratio;
  logic [5:0]  e_init;
  logic [29:0] x_init;
  logic [30:0] t_prod, q_start;
  logic [31:0] k_round;
  logic [15:0] k_val;
  logic [31:0] abs_hx, abs_hy, abs_ix, abs_iy, dec_mag, dec_val, sq_op, b_h, b_val;
  logic [32:0] bdx, bdy, bmx, bmy, b_mag;
  logic [16:0] a_blend;
  logic [33:0] b_sgn, b_sum;
  logic [1:0]  sq_next;
  logic [65:0] sq_ext;

  always_comb begin
    // instantaneous velocity for the current axis
    sel_p    = axis ? py : px;
    sel_l    = axis ? last_y : last_x;
    d_diff   = {sel_p[31], sel_p} - {sel_l[31], sel_l};
    d_mag    = d_diff[32] ? 32'(~d_diff + 33'd1) : d_diff[31:0];
    v_clamp  = (drsp.q > {8'd0, VEL_CLAMP}) ? VEL_CLAMP : drsp.q[47:0];
    g_mag    = mrsp.p[63:8];
    g_neg    = ~g_mag[31:0] + 32'd1;
    if (neg) inst_val = (g_mag > 56'h8000_0000) ? INT_MIN : g_neg;
    else     inst_val = (g_mag > 56'h7FFF_FFFF) ? INT_MAX : g_mag[31:0];

    // decay factor
    ratio    = drsp.q[35:0];
    e_init   = (ratio[35:21] != '0) ? EXP_MAX : {1'b0, ratio[20:16]};
    x_init   = {ratio[15:0], 14'd0};
    t_prod   = mrsp.p[60:30];
    q_start  = (tsum[31] || tsum == '0) ? '0 : tsum[30:0];
    k_round  = {1'b0, qe} + 32'd8192;
    k_val    = (k_round[31:30] != 2'd0) ? 16'hFFFF : k_round[29:14];

    // magnitudes
    abs_hx   = held_x[31] ? (~held_x + 32'd1) : held_x;
    abs_hy   = held_y[31] ? (~held_y + 32'd1) : held_y;
    abs_ix   = ix[31] ? (~ix + 32'd1) : ix;
    abs_iy   = iy[31] ? (~iy + 32'd1) : iy;

    // decay result
    dec_mag  = mrsp.p[47:16];
    dec_val  = (axis ? held_y[31] : held_x[31]) ? (~dec_mag + 32'd1) : dec_mag;

    // blend toward the instant velocity
    bdx      = {ix[31], ix} - {held_x[31], held_x};
    bdy      = {iy[31], iy} - {held_y[31], held_y};
    bmx      = bdx[32] ? (~bdx + 33'd1) : bdx;
    bmy      = bdy[32] ? (~bdy + 33'd1) : bdy;
    a_blend  = 17'h10000 - {1'b0, kf};
    b_mag    = mrsp.p[48:16];
    b_sgn    = neg ? (~{1'b0, b_mag} + 34'd1) : {1'b0, b_mag};
    b_h      = axis ? held_y : held_x;
    b_sum    = {{2{b_h[31]}}, b_h} + b_sgn;
    if (b_sum[33] && b_sum[32:31] != 2'b11)       b_val = INT_MIN;
    else if (!b_sum[33] && b_sum[32:31] != 2'b00) b_val = INT_MAX;
    else                                          b_val = b_sum[31:0];

    // speed-squared operands: instant x, y then held x, y
    sq_next  = sqi + 2'd1;
    case (sq_next)
      2'd0:    sq_op = abs_ix;
      2'd1:    sq_op = abs_iy;
      2'd2:    sq_op = abs_hx;
      default: sq_op = abs_hy;
    endcase
    sq_ext   = {2'b00, mrsp.p[63:0]};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
      tau  <= '0;
      peak <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        vphd_pkg::CFG_GAIN:  gain <= cfg.data[15:0];
        vphd_pkg::CFG_DECAY: tau  <= cfg.data;
        vphd_pkg::CFG_MODE:  peak <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_x    <= '0;
      last_y    <= '0;
      held_x    <= '0;
      held_y    <= '0;
      have_last <= 1'b0;
      out_valid <= 1'b0;
      mreq.go   <= 1'b0;
      dreq.go   <= 1'b0;
    end else begin
      mreq.go <= 1'b0;
      dreq.go <= 1'b0;
      if (vel.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pos.valid) begin
            px   <= pos.pos_x;
            py   <= pos.pos_y;
            dt   <= pos.delta_time_us;
            axis <= 1'b0;
            if (have_last && pos.delta_time_us != '0) begin
              state <= ST_INST;
            end else begin
              ix    <= '0;
              iy    <= '0;
              state <= ST_KSTART;
            end
          end
        end
        ST_INST: begin
          neg     <= d_diff[32];
          mreq.go <= 1'b1;
          mreq.a  <= {16'd0, d_mag};
          mreq.b  <= VEL_SCALE;
          state   <= ST_V_MUL;
        end
        ST_V_MUL: begin
          if (mrsp.done) begin
            dreq.go <= 1'b1;
            dreq.n  <= mrsp.p[55:0];
            dreq.d  <= {4'd0, dt};
            state   <= ST_V_DIV;
          end
        end
        ST_V_DIV: begin
          if (drsp.done) begin
            mreq.go <= 1'b1;
            mreq.a  <= v_clamp;
            mreq.b  <= {16'd0, gain};
            state   <= ST_V_GAIN;
          end
        end
        ST_V_GAIN: begin
          if (mrsp.done) begin
            if (axis) begin
              iy    <= inst_val;
              state <= ST_KSTART;
            end else begin
              ix    <= inst_val;
              axis  <= 1'b1;
              state <= ST_INST;
            end
          end
        end
        ST_KSTART: begin
          last_x    <= px;
          last_y    <= py;
          have_last <= 1'b1;
          if (tau == '0) begin
            held_x <= ix;
            held_y <= iy;
            state  <= ST_DONE;
          end else begin
            dreq.go <= 1'b1;
            dreq.n  <= {20'd0, dt, 16'd0};
            dreq.d  <= tau;
            state   <= ST_R_DIV;
          end
        end
        ST_R_DIV: begin
          if (drsp.done) begin
            ecnt    <= e_init;
            xq      <= x_init;
            tsum    <= {1'b0, ONE_Q30};
            tk      <= 4'd1;
            mreq.go <= 1'b1;
            mreq.a  <= {17'd0, ONE_Q30};
            mreq.b  <= {2'd0, x_init};
            state   <= ST_T_MUL;
          end
        end
        ST_T_MUL: begin
          if (mrsp.done) begin
            dreq.go <= 1'b1;
            dreq.n  <= {25'd0, t_prod};
            dreq.d  <= {20'd0, tk};
            state   <= ST_T_DIV;
          end
        end
        ST_T_DIV: begin
          if (drsp.done) begin
            // odd terms subtract, even terms add
            tsum <= tk[0] ? (tsum - {1'b0, drsp.q[30:0]}) : (tsum + {1'b0, drsp.q[30:0]});
            if (tk == TAYLOR_LAST) begin
              state <= ST_E_START;
            end else begin
              tk      <= tk + 4'd1;
              mreq.go <= 1'b1;
              mreq.a  <= {17'd0, drsp.q[30:0]};
              mreq.b  <= {2'd0, xq};
              state   <= ST_T_MUL;
            end
          end
        end
        ST_E_START: begin
          qe <= q_start;
          if (ecnt == '0) begin
            state <= ST_KFIN;
          end else begin
            mreq.go <= 1'b1;
            mreq.a  <= {17'd0, q_start};
            mreq.b  <= EINV_Q30;
            state   <= ST_E_MUL;
          end
        end
        ST_E_MUL: begin
          if (mrsp.done) begin
            qe   <= t_prod;
            ecnt <= ecnt - 6'd1;
            if (ecnt == 6'd1) begin
              state <= ST_KFIN;
            end else begin
              mreq.go <= 1'b1;
              mreq.a  <= {17'd0, t_prod};
              mreq.b  <= EINV_Q30;
            end
          end
        end
        ST_KFIN: begin
          kf      <= k_val;
          axis    <= 1'b0;
          mreq.go <= 1'b1;
          mreq.a  <= {16'd0, abs_hx};
          mreq.b  <= {16'd0, k_val};
          state   <= ST_D_MUL;
        end
        ST_D_MUL: begin
          if (mrsp.done) begin
            if (!axis) begin
              held_x  <= dec_val;
              axis    <= 1'b1;
              mreq.go <= 1'b1;
              mreq.a  <= {16'd0, abs_hy};
              mreq.b  <= {16'd0, kf};
            end else begin
              held_y <= dec_val;
              if (peak) begin
                sqdiff  <= '0;
                sqi     <= 2'd0;
                mreq.go <= 1'b1;
                mreq.a  <= {16'd0, abs_ix};
                mreq.b  <= abs_ix;
                state   <= ST_SQ_MUL;
              end else begin
                axis    <= 1'b0;
                neg     <= bdx[32];
                mreq.go <= 1'b1;
                mreq.a  <= {15'd0, bmx};
                mreq.b  <= {15'd0, a_blend};
                state   <= ST_B_MUL;
              end
            end
          end
        end
        ST_SQ_MUL: begin
          if (mrsp.done) begin
            sqdiff <= sqi[1] ? (sqdiff - sq_ext) : (sqdiff + sq_ext);
            if (sqi == 2'd3) begin
              state <= ST_PEAK;
            end else begin
              sqi     <= sq_next;
              mreq.go <= 1'b1;
              mreq.a  <= {16'd0, sq_op};
              mreq.b  <= sq_op;
            end
          end
        end
        ST_PEAK: begin
          // replace when the new speed squared is strictly larger
          if (!sqdiff[65] && sqdiff != '0) begin
            held_x <= ix;
            held_y <= iy;
          end
          state <= ST_DONE;
        end
        ST_B_MUL: begin
          if (mrsp.done) begin
            if (!axis) begin
              held_x  <= b_val;
              axis    <= 1'b1;
              neg     <= bdy[32];
              mreq.go <= 1'b1;
              mreq.a  <= {15'd0, bmy};
              mreq.b  <= {15'd0, a_blend};
            end else begin
              held_y <= b_val;
              state  <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || vel.ready) begin
            out_x     <= held_x;
            out_y     <= held_y;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pos.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign vel.valid = out_valid;
  assign vel.vel_x = out_x;
  assign vel.vel_y = out_y;

endmodule

// ===== src/vphd_checker.sv =====
`timescale 1ns / 1ps

module vphd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] vel_x,
  input logic [31:0] vel_y
);

  // no result word is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // input is not ready in the cycle after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accepting a word");

  // a result cannot appear on the cycle after a word is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result word appeared one cycle after input");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vel_x) && $stable(vel_y))
    else $error("stalled result word changed");

endmodule

bind velocity_peak_hold_decay vphd_checker u_vphd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pos.valid),
  .in_ready  (pos.ready),
  .out_valid (vel.valid),
  .out_ready (vel.ready),
  .vel_x     (vel.vel_x),
  .vel_y     (vel.vel_y)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic MODE_BLEND = 1'b0;
  localparam logic MODE_PEAK  = 1'b1;
  // index with no register behind it
  localparam logic [vphd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam longint VEL_CLAMP = 64'sd140737488355328;  // 2^47
  localparam logic [63:0] EINV_Q30 = 64'd395007542;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 3000;
  localparam int QUIET_WORDS = 150;
  localparam int LONG_HOLD = 600;

  typedef enum logic {OP_WORD, OP_REG} stim_kind_t;

  typedef struct {
    stim_kind_t                          kind;
    logic [31:0]                         x;
    logic [31:0]                         y;
    logic [19:0]                         dt;
    logic [vphd_pkg::CFG_IDX_W-1:0]      idx;
    logic [vphd_pkg::CFG_DATA_W-1:0]     data;
  } stim_op_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } vel_word_t;

  logic clk;
  logic rst;

  vphd_pos_if pos_bus ();
  vphd_vel_if vel_bus ();
  vphd_cfg_if cfg_bus ();

  velocity_peak_hold_decay u_dut (
    .clk (clk),
    .rst (rst),
    .pos (pos_bus),
    .vel (vel_bus),
    .cfg (cfg_bus)
  );

  // stimulus and expectations
  stim_op_t  pending[$];
  vel_word_t vel_expected[$];
  int words_total, regs_total;
  int words_sent, words_taken, regs_taken, results_seen;
  int mismatches;
  int idle_pct;
  logic quiet;
  logic pos_fire, cfg_fire;
  logic [31:0] walk_x, walk_y;
  int gap_left;
  int hold_left;
  logic long_hold_done;

  // predictor copy of registers and state
  logic [15:0] cur_gain;
  logic [23:0] cur_tau;
  logic        cur_mode;
  logic signed [31:0] prev_x, prev_y, hold_vx, hold_vy;
  logic have_prev;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // position delta over time, gain applied (Q8.8), signed whole position units per second
  function automatic logic signed [31:0] rate_of(input logic signed [31:0] now,
                                                 input logic signed [31:0] prev,
                                                 input logic [19:0] dt);
    longint dpos, span, v, gl;
    dpos = longint'(now) - longint'(prev);
    span = dt;
    gl = cur_gain;
    v = (dpos * 1000000) / span;
    if (v > VEL_CLAMP) v = VEL_CLAMP;
    else if (v < -VEL_CLAMP) v = -VEL_CLAMP;
    return clip32((v * gl) / 256);
  endfunction

  // K = exp(-dt/tau) in Q0.16: truncated Taylor series on the fraction,
  // then e^-1 once per whole unit, up to 32
  function automatic logic [15:0] decay_coeff(input logic [19:0] dt, input logic [23:0] tau);
    logic [63:0] ratio, whole, frac, term, q;
    longint sum;
    ratio = ({44'd0, dt} << 16) / {40'd0, tau};
    whole = ratio >> 16;
    frac = (ratio & 64'hFFFF) << 14;
    term = 64'd1 << 30;
    sum = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * frac) >> 30) / 64'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    q = (sum > 0) ? 64'(sum) : 64'd0;
    for (int j = 0; j < whole && j < 32; j++) q = (q * EINV_Q30) >> 30;
    q = (q + 64'd8192) >> 14;
    if (q > 64'd65535) q = 64'd65535;
    return q[15:0];
  endfunction

  function automatic logic [63:0] sq_mag(input logic signed [31:0] v);
    longint m;
    m = v;
    if (m < 0) m = -m;
    return m * m;
  endfunction

  // advance the velocity tracker by one position word
  function automatic vel_word_t predict_velocity(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic [19:0] dt);
    logic signed [31:0] ix, iy;
    longint kl, a;
    vel_word_t w;
    ix = '0;
    iy = '0;
    if (have_prev && dt != 0) begin
      ix = rate_of(x, prev_x, dt);
      iy = rate_of(y, prev_y, dt);
    end
    prev_x = x;
    prev_y = y;
    have_prev = 1'b1;
    if (cur_tau == 0) begin
      hold_vx = ix;
      hold_vy = iy;
    end else begin
      kl = decay_coeff(dt, cur_tau);
      hold_vx = 32'((longint'(hold_vx) * kl) / 65536);
      hold_vy = 32'((longint'(hold_vy) * kl) / 65536);
      if (cur_mode == MODE_PEAK) begin
        if (sq_mag(ix) + sq_mag(iy) > sq_mag(hold_vx) + sq_mag(hold_vy)) begin
          hold_vx = ix;
          hold_vy = iy;
        end
      end else begin
        a = 65536 - kl;
        hold_vx = clip32(longint'(hold_vx) + ((longint'(ix) - longint'(hold_vx)) * a) / 65536);
        hold_vy = clip32(longint'(hold_vy) + ((longint'(iy) - longint'(hold_vy)) * a) / 65536);
      end
    end
    w.vx = hold_vx;
    w.vy = hold_vy;
    return w;
  endfunction

  task automatic push_word(input logic [31:0] x, input logic [31:0] y, input logic [19:0] dt);
    stim_op_t op;
    op.kind = OP_WORD;
    op.x = x;
    op.y = y;
    op.dt = dt;
    op.idx = '0;
    op.data = '0;
    pending.push_back(op);
    words_total++;
  endtask

  task automatic push_reg(input logic [vphd_pkg::CFG_IDX_W-1:0] idx,
                          input logic [vphd_pkg::CFG_DATA_W-1:0] data);
    stim_op_t op;
    op.kind = OP_REG;
    op.x = '0;
    op.y = '0;
    op.dt = '0;
    op.idx = idx;
    op.data = data;
    pending.push_back(op);
    regs_total++;
  endtask

  // mostly a random walk in position, some full-range and extreme jumps
  task automatic push_random(input int count);
    logic [31:0] x, y;
    logic [19:0] dt;
    int span;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          x = $urandom;
          y = $urandom;
        end
        2: begin
          x = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
          y = $urandom_range(0, 1) ? 32'h80000000 : 32'h00000000;
        end
        default: begin
          span = 1 << (4 * $urandom_range(1, 5));
          x = walk_x + $urandom_range(0, 2 * span) - span;
          y = walk_y + $urandom_range(0, 2 * span) - span;
        end
      endcase
      walk_x = x;
      walk_y = y;
      case ($urandom_range(0, 15))
        0: dt = '0;
        1, 2, 3: dt = 20'($urandom_range(0, 20'hFFFFF));
        default: dt = 20'($urandom_range(1, 20000));
      endcase
      push_word(x, y, dt);
    end
  endtask

  // sender: one op from the queue at a time, registers only when idle
  always @(negedge clk) begin
    stim_op_t op;
    if (rst) begin
      pos_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else if ((pos_bus.valid && !pos_fire) || (cfg_bus.valid && !cfg_fire)) begin
      // word still on offer
    end else if (gap_left != 0) begin
      pos_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending.size() == 0 ||
                 (pending[0].kind == OP_REG && vel_expected.size() != 0)) begin
      pos_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else begin
      op = pending.pop_front();
      if (op.kind == OP_REG) begin
        pos_bus.valid <= 1'b0;
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= op.idx;
        cfg_bus.data <= op.data;
      end else begin
        cfg_bus.valid <= 1'b0;
        pos_bus.valid <= 1'b1;
        pos_bus.pos_x <= op.x;
        pos_bus.pos_y <= op.y;
        pos_bus.delta_time_us <= op.dt;
        if (words_sent % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
          endcase
        end
        words_sent++;
        quiet = (words_sent >= words_total - QUIET_WORDS);
      end
      if (!quiet && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 4);
    end
  end

  // receiver: short random stalls, one long hold-off early on
  always @(negedge clk) begin
    if (rst) begin
      vel_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      vel_bus.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 40) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      vel_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      hold_left = $urandom_range(0, 3);
      vel_bus.ready <= 1'b0;
    end else begin
      vel_bus.ready <= 1'b1;
    end
  end

  // monitor: check results, track register writes, predict accepted words
  always @(posedge clk) begin
    vel_word_t want;
    if (rst) begin
      pos_fire <= 1'b0;
      cfg_fire <= 1'b0;
      cur_gain = 16'd256;
      cur_tau = '0;
      cur_mode = MODE_PEAK;
      prev_x = '0;
      prev_y = '0;
      have_prev = 1'b0;
      hold_vx = '0;
      hold_vy = '0;
    end else begin
      pos_fire <= pos_bus.valid && pos_bus.ready;
      cfg_fire <= cfg_bus.valid && cfg_bus.ready;
      if (vel_bus.valid && vel_bus.ready) begin
        results_seen++;
        if (vel_expected.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected velocity word: vel_x %0d vel_y %0d",
                     $signed(vel_bus.vel_x), $signed(vel_bus.vel_y));
          mismatches++;
        end else begin
          want = vel_expected.pop_front();
          if (vel_bus.vel_x !== want.vx || vel_bus.vel_y !== want.vy) begin
            if (mismatches < 10)
              $display("word %0d mismatch: vel_x exp %0d got %0d, vel_y exp %0d got %0d",
                       results_seen, want.vx, $signed(vel_bus.vel_x),
                       want.vy, $signed(vel_bus.vel_y));
            mismatches++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        regs_taken++;
        case (cfg_bus.index)
          vphd_pkg::CFG_GAIN:  cur_gain = cfg_bus.data[15:0];
          vphd_pkg::CFG_DECAY: cur_tau = cfg_bus.data;
          vphd_pkg::CFG_MODE:  cur_mode = cfg_bus.data[0];
          default: ;
        endcase
      end
      if (pos_bus.valid && pos_bus.ready) begin
        words_taken++;
        vel_expected.push_back(predict_velocity(pos_bus.pos_x, pos_bus.pos_y,
                                                pos_bus.delta_time_us));
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (pos_bus.valid && pos_bus.ready) || (vel_bus.valid && vel_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    pos_bus.valid = 1'b0;
    pos_bus.pos_x = '0;
    pos_bus.pos_y = '0;
    pos_bus.delta_time_us = '0;
    vel_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    gap_left = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    idle_pct = 0;
    quiet = 1'b0;
    walk_x = '0;
    walk_y = '0;

    // reset values: unit gain, no decay
    push_word(32'd100, 32'd200, 20'd1000);             // first word gives zero
    push_word(32'h7FFFFFFF, 32'h80000000, 20'd1);      // saturates both ways
    push_word(32'h80000000, 32'h7FFFFFFF, 20'd1);
    push_word(32'd0, 32'd0, 20'd0);                    // zero time
    push_word(32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF);
    push_word(32'd256, -32'sd256, 20'd1000000);
    // peak hold with decay
    push_reg(vphd_pkg::CFG_DECAY, 24'd1000);
    push_word(32'd1000, 32'd0, 20'd1000);
    push_word(32'd1000, 32'd0, 20'd0);                 // K clamps just under one
    push_word(32'd1100, 32'd0, 20'd100);
    push_word(32'd6100, 32'd5000, 20'd100);
    // low-pass blend, upper data bits ignored
    push_reg(vphd_pkg::CFG_MODE, {23'h7FFFFF, MODE_BLEND});
    push_word(32'd8100, 32'd5000, 20'd500);
    push_word(32'd8100, 32'd5000, 20'd0);
    push_word(-32'sd3000, 32'd4000, 20'd300);
    push_reg(CFG_UNUSED, 24'hFFFFFF);
    push_word(32'd0, 32'd0, 20'd1000);
    push_reg(vphd_pkg::CFG_DECAY, 24'd1);              // tau of one: full decay on the long step
    push_word(32'd100, 32'd100, 20'hFFFFF);
    push_word(32'd0, 32'd0, 20'd1);

    // random phases over register settings
    push_reg(vphd_pkg::CFG_DECAY, 24'd0);
    push_reg(vphd_pkg::CFG_GAIN, {8'hFF, 16'hFFFF});
    push_random(400);
    push_reg(vphd_pkg::CFG_GAIN, 24'd0);
    push_random(100);
    push_reg(vphd_pkg::CFG_GAIN, {8'($urandom), 16'($urandom)});
    push_reg(vphd_pkg::CFG_DECAY, 24'($urandom_range(1, 200000)));
    push_reg(vphd_pkg::CFG_MODE, {23'($urandom), MODE_PEAK});
    push_random(150);
    push_reg(vphd_pkg::CFG_DECAY, 24'hFFFFFF);
    push_reg(vphd_pkg::CFG_MODE, {23'd0, MODE_BLEND});
    push_random(100);
    push_reg(vphd_pkg::CFG_GAIN, 24'd256);
    push_reg(vphd_pkg::CFG_DECAY, 24'($urandom_range(1, 5000)));
    push_random(100);
    push_reg(vphd_pkg::CFG_DECAY, 24'd0);
    push_reg(vphd_pkg::CFG_MODE, {23'd0, MODE_PEAK});
    push_reg(vphd_pkg::CFG_GAIN, 24'($urandom_range(0, 16'hFFFF)));
    push_random(600);
    push_reg(vphd_pkg::CFG_GAIN, 24'd256);
    push_random(500);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain, then let any stray word show up
    do @(negedge clk);
    while (words_taken != words_total || regs_taken != regs_total ||
           vel_expected.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && vel_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
